// File: rtl/core/pal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types and constants of the positional array list: request and
// response beats, status and operation codes, and the cell control word.
// ----------------------------------------------------------------------------
package pal_pkg;

    // list size and derived widths
    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = $clog2(CAPACITY);
    localparam int IDX_W    = 7;
    localparam int DATA_W   = 32;
    localparam int CMP_W    = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_SEARCH = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_INDEX = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    // request beat
    typedef struct packed {
        logic [1:0]               operation;
        logic [IDX_W-1:0]         index;
        logic signed [DATA_W-1:0] value;
    } t_req;

    // response beat
    typedef struct packed {
        logic [2:0]               status;
        logic signed [DATA_W-1:0] read_value;
        logic [5:0]               found_position;
        logic [6:0]               entry_count;
    } t_rsp;

    // what a cell does with its entry this cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_TAKE_LOWER,
        CELL_TAKE_UPPER
    } t_cell_op;

    // control word from the sequencer to one cell
    typedef struct packed {
        t_cell_op op;
        logic     sel;     // cell position equals the request index
        logic     active;  // cell position is below the count
    } t_cell_ctrl;

endpackage

// File: rtl/core/pal_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_cell
// One list slot: holds an entry, loads it from the request or from either
// neighbor, and registers a gated read tap and a search match flag.
// ----------------------------------------------------------------------------
module pal_cell (
    input  logic                                i_clk,
    input  pal_pkg::t_cell_ctrl                 i_ctrl,
    input  logic signed [pal_pkg::DATA_W-1:0]   i_lower,
    input  logic signed [pal_pkg::DATA_W-1:0]   i_upper,
    input  logic signed [pal_pkg::DATA_W-1:0]   i_value,
    output logic signed [pal_pkg::DATA_W-1:0]   o_entry,
    output logic signed [pal_pkg::DATA_W-1:0]   o_pick,
    output logic                                o_match
);

    logic signed [pal_pkg::DATA_W-1:0] r_entry;
    logic signed [pal_pkg::DATA_W-1:0] n_entry;
    logic signed [pal_pkg::DATA_W-1:0] r_pick;
    logic                              r_match;

    // next entry from the shift or load command
    always_comb begin
        case (i_ctrl.op)
            pal_pkg::CELL_LOAD:       n_entry = i_value;
            pal_pkg::CELL_TAKE_LOWER: n_entry = i_lower;
            pal_pkg::CELL_TAKE_UPPER: n_entry = i_upper;
            default:                  n_entry = r_entry;
        endcase
    end

    // entry, read tap and match flag
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_pick  <= i_ctrl.sel ? r_entry : '0;
        r_match <= i_ctrl.active && (r_entry == i_value);
    end

    assign o_entry = r_entry;
    assign o_pick  = r_pick;
    assign o_match = r_match;

endmodule

// File: rtl/core/positional_array_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_list
// Ordered list of signed 32-bit entries held in a row of cells, with insert,
// remove, read and first-match search by position.
// ----------------------------------------------------------------------------
//  channel    ports                    handshake
//  request    i_req                    taken when start && !busy
//  response   o_rsp                    valid for one cycle with o_done
//
//  a request passes S_IDLE and S_WORK: the accept edge shifts the cells and
//  registers their compares, the next edge reduces the row and sends the beat
//  busy is high while in S_WORK, between accept and response, so a new
//  request can be taken in the cycle that carries o_done
//  synchronous active-low reset clears the count and the sequencer; entries
//  are not cleared, only slots below the count are ever reported
//  o_done cannot be stalled by the receiver
// ----------------------------------------------------------------------------
module positional_array_list (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  pal_pkg::t_req   i_req,
    output logic            o_done,
    output pal_pkg::t_rsp   o_rsp
);

    localparam int N = pal_pkg::CAPACITY;

    typedef enum logic {
        S_IDLE,
        S_WORK
    } t_state;

    t_state                     r_state;
    logic [pal_pkg::CNT_W-1:0]  r_count;
    logic [pal_pkg::CNT_W-1:0]  n_count;
    logic [1:0]                 r_op;
    logic [2:0]                 r_status;
    logic [2:0]                 n_status;
    logic [2:0]                 w_status;

    logic                       w_accept;
    logic [pal_pkg::CMP_W-1:0]  w_idx;
    logic [pal_pkg::CMP_W-1:0]  w_cnt;
    logic                       w_ins_ok;
    logic                       w_rem_ok;

    pal_pkg::t_cell_ctrl                 w_ctrl  [N];
    logic signed [pal_pkg::DATA_W-1:0]   w_entry [N];
    logic signed [pal_pkg::DATA_W-1:0]   w_pick  [N];
    logic [N-1:0]                        w_match;
    logic [N-1:0]                        w_first;
    logic signed [pal_pkg::DATA_W-1:0]   w_rd;
    logic [pal_pkg::POS_W-1:0]           w_pos;

    assign w_accept = start && (r_state == S_IDLE);
    assign busy     = (r_state == S_WORK);
    assign w_idx    = pal_pkg::CMP_W'(i_req.index);
    assign w_cnt    = pal_pkg::CMP_W'(r_count);

    // request decode: status known at accept except for search
    always_comb begin
        n_status = pal_pkg::ST_OK;
        n_count  = r_count;
        w_ins_ok = 1'b0;
        w_rem_ok = 1'b0;
        if (i_req.operation == pal_pkg::OP_INSERT) begin
            if (w_cnt >= pal_pkg::CMP_W'(N)) begin
                n_status = pal_pkg::ST_FULL;
            end else if (w_idx > w_cnt) begin
                n_status = pal_pkg::ST_BAD_INDEX;
            end else begin
                w_ins_ok = 1'b1;
                n_count  = r_count + 1'b1;
            end
        end else if (r_count == '0) begin
            n_status = pal_pkg::ST_EMPTY;
        end else if (i_req.operation == pal_pkg::OP_SEARCH) begin
            n_status = pal_pkg::ST_NOT_FOUND;
        end else if (w_idx >= w_cnt) begin
            n_status = pal_pkg::ST_BAD_INDEX;
        end else if (i_req.operation == pal_pkg::OP_REMOVE) begin
            w_rem_ok = 1'b1;
            n_count  = r_count - 1'b1;
        end
    end

    // row of cells
    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            logic signed [pal_pkg::DATA_W-1:0] w_lower;
            logic signed [pal_pkg::DATA_W-1:0] w_upper;

            if (g == 0) begin : g_first
                assign w_lower = '0;
            end else begin : g_mid_lo
                assign w_lower = w_entry[g-1];
            end
            if (g == N - 1) begin : g_last
                assign w_upper = '0;
            end else begin : g_mid_hi
                assign w_upper = w_entry[g+1];
            end

            // per-cell command
            always_comb begin
                w_ctrl[g].sel    = (pal_pkg::CMP_W'(g) == w_idx);
                w_ctrl[g].active = (pal_pkg::CMP_W'(g) < w_cnt);
                w_ctrl[g].op     = pal_pkg::CELL_HOLD;
                if (w_accept && w_ins_ok) begin
                    if (pal_pkg::CMP_W'(g) == w_idx) begin
                        w_ctrl[g].op = pal_pkg::CELL_LOAD;
                    end else if (pal_pkg::CMP_W'(g) > w_idx) begin
                        w_ctrl[g].op = pal_pkg::CELL_TAKE_LOWER;
                    end
                end else if (w_accept && w_rem_ok) begin
                    if (pal_pkg::CMP_W'(g) >= w_idx) begin
                        w_ctrl[g].op = pal_pkg::CELL_TAKE_UPPER;
                    end
                end
            end

            pal_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl[g]),
                .i_lower (w_lower),
                .i_upper (w_upper),
                .i_value (i_req.value),
                .o_entry (w_entry[g]),
                .o_pick  (w_pick[g]),
                .o_match (w_match[g])
            );
        end
    endgenerate

    // lowest matching slot as one-hot
    assign w_first = w_match & ~(w_match - 1'b1);

    // reduce read taps and encode the first match
    always_comb begin
        w_rd  = '0;
        w_pos = '0;
        for (int i = 0; i < N; i++) begin
            w_rd  = w_rd | w_pick[i];
            w_pos = w_pos | (w_first[i] ? pal_pkg::POS_W'(i) : '0);
        end
    end

    // final status for search
    always_comb begin
        w_status = r_status;
        if (r_op == pal_pkg::OP_SEARCH && r_status == pal_pkg::ST_NOT_FOUND
                && w_match != '0) begin
            w_status = pal_pkg::ST_OK;
        end
    end

    // sequencer, count and response beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state  <= S_WORK;
                        r_count  <= n_count;
                        r_op     <= i_req.operation;
                        r_status <= n_status;
                    end
                end
                S_WORK: begin
                    r_state                    <= S_IDLE;
                    o_done                     <= 1'b1;
                    o_rsp.status               <= w_status;
                    o_rsp.read_value           <= (r_op == pal_pkg::OP_READ
                                                   && w_status == pal_pkg::ST_OK)
                                                  ? w_rd : '0;
                    o_rsp.found_position       <= (r_op == pal_pkg::OP_SEARCH
                                                   && w_status == pal_pkg::ST_OK)
                                                  ? 6'(w_pos) : '0;
                    o_rsp.entry_count          <= 7'(r_count);
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // count never exceeds the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= pal_pkg::CNT_W'(N))
        else $error("count above capacity");

    // every work state is followed by a response beat
    a_done_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_done)
        else $error("response missing after work cycle");

    // count changes only after an accepted request
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_count))
        else $error("count changed without a request");

    // a reported search hit names a slot below the count
    a_hit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status == pal_pkg::ST_OK)
            |-> (7'(o_rsp.found_position) < o_rsp.entry_count
                 || o_rsp.found_position == '0))
        else $error("search hit outside the list");

endmodule

// File: tb/sv/positional_array_list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_list_checker
// Watches the request and response beats of the positional array list, keeps
// its own copy of the list to work out each response, and compares every
// response field against the oldest expected one. Reports mismatches and
// hands the count of failures and outstanding responses to the top.
// ----------------------------------------------------------------------------
module positional_array_list_checker
    import pal_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_busy,
    input  t_req  i_req,
    input  logic  i_done,
    input  t_rsp  i_rsp,
    output int    o_error_count,
    output int    o_pending
);

    // shadow list contents and length
    logic signed [DATA_W-1:0] list_mem [CAPACITY];
    int                       list_len;

    // responses worked out but not yet seen
    t_rsp expected_rsp [$];
    int   error_count;

    // apply one request to the shadow list and return its response
    function automatic t_rsp apply_list_request(t_req r);
        t_rsp        e;
        int          ix;
        int          i;
        e      = '0;
        e.status = ST_OK;
        ix     = int'(r.index);
        if (r.operation == OP_INSERT) begin
            if (list_len >= CAPACITY) begin
                e.status = ST_FULL;
            end else if (ix > list_len) begin
                e.status = ST_BAD_INDEX;
            end else begin
                for (i = list_len; i > ix; i--)
                    list_mem[i] = list_mem[i-1];
                list_mem[ix] = r.value;
                list_len++;
            end
        end else if (list_len == 0) begin
            e.status = ST_EMPTY;
        end else if (r.operation == OP_REMOVE) begin
            if (ix >= list_len) begin
                e.status = ST_BAD_INDEX;
            end else begin
                for (i = ix; i + 1 < list_len; i++)
                    list_mem[i] = list_mem[i+1];
                list_len--;
            end
        end else if (r.operation == OP_READ) begin
            if (ix >= list_len)
                e.status = ST_BAD_INDEX;
            else
                e.read_value = list_mem[ix];
        end else begin
            // first match wins
            e.status = ST_NOT_FOUND;
            for (i = 0; i < list_len; i++) begin
                if (list_mem[i] == r.value) begin
                    e.status         = ST_OK;
                    e.found_position = 6'(i);
                    break;
                end
            end
        end
        e.entry_count = 7'(list_len);
        return e;
    endfunction

    // one field compare, x-aware
    function automatic void check_rsp_field(string name, logic signed [32:0] want,
                                            logic signed [32:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    initial begin
        error_count   = 0;
        list_len      = 0;
    end

    // response compare first, then new request prediction
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            list_len = 0;
            expected_rsp.delete();
        end else begin
            if (i_done) begin
                if (expected_rsp.size() == 0) begin
                    $error("response beat with no request outstanding");
                    error_count++;
                end else begin
                    want = expected_rsp.pop_front();
                    check_rsp_field("status", 33'(want.status), 33'(i_rsp.status));
                    check_rsp_field("read_value", 33'(want.read_value),
                                    33'(i_rsp.read_value));
                    check_rsp_field("found_position", 33'(want.found_position),
                                    33'(i_rsp.found_position));
                    check_rsp_field("entry_count", 33'(want.entry_count),
                                    33'(i_rsp.entry_count));
                end
            end
            if (i_start && !i_busy)
                expected_rsp.push_back(apply_list_request(i_req));
        end
        o_pending     <= expected_rsp.size();
        o_error_count <= error_count;
    end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the positional array list. A short directed run
// walks the empty, bad index, append, duplicate and first-match cases, then
// random phases fill the list to capacity, mix, and drain it to empty, with
// random idle bursts on the request side. The checker does all comparing.
// ----------------------------------------------------------------------------
module tb_top;
    import pal_pkg::*;

    localparam int RANDOM_ITEMS = 1725;
    localparam int QUIET_TAIL   = 250;
    localparam int CYCLE_LIMIT  = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic o_done;
    t_rsp o_rsp;

    int   chk_errors;
    int   chk_pending;
    int   cycle_count = 0;

    // stimulus bookkeeping: length the list should have, recent inserts
    int                       shadow_len  = 0;
    logic signed [DATA_W-1:0] value_pool [$];
    int                       items_sent  = 0;
    int                       full_hits   = 0;
    int                       empty_hits  = 0;

    always #5 i_clk = ~i_clk;

    positional_array_list dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    positional_array_list_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_req         (i_req),
        .i_done        (o_done),
        .i_rsp         (o_rsp),
        .o_error_count (chk_errors),
        .o_pending     (chk_pending)
    );

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic t_req mk_req(logic [1:0] op, int idx, logic signed [31:0] val);
        t_req r;
        r.operation = op;
        r.index     = IDX_W'(idx);
        r.value     = val;
        return r;
    endfunction

    // follow the list length so random indexes land mostly in range
    function automatic void track_list_len(t_req r);
        if (r.operation == OP_INSERT) begin
            if (shadow_len < CAPACITY && int'(r.index) <= shadow_len) begin
                shadow_len++;
                value_pool.push_back(r.value);
                if (value_pool.size() > 32)
                    void'(value_pool.pop_front());
                if (shadow_len == CAPACITY)
                    full_hits++;
            end
        end else if (r.operation == OP_REMOVE) begin
            if (shadow_len > 0 && int'(r.index) < shadow_len) begin
                shadow_len--;
                if (shadow_len == 0)
                    empty_hits++;
            end
        end
    endfunction

    // random request, biased toward insert by insert_pct
    task automatic make_list_request(input int insert_pct, output t_req r);
        int roll;
        int mode;
        roll = $urandom_range(0, 99);
        if (roll < insert_pct) begin
            r.operation = OP_INSERT;
        end else begin
            case ($urandom_range(0, 2))
                0:       r.operation = OP_REMOVE;
                1:       r.operation = OP_READ;
                default: r.operation = OP_SEARCH;
            endcase
        end

        // index: mostly in range, some at the edge, some anywhere
        mode = $urandom_range(0, 19);
        if (mode < 2)
            r.index = IDX_W'($urandom_range(0, CAPACITY));
        else if (mode < 3)
            r.index = IDX_W'(shadow_len);
        else if (r.operation == OP_INSERT)
            r.index = IDX_W'($urandom_range(0, shadow_len));
        else
            r.index = (shadow_len == 0) ? '0 : IDX_W'($urandom_range(0, shadow_len - 1));

        // value: searches mostly hit recent inserts; small values make duplicates
        mode = $urandom_range(0, 9);
        if (r.operation == OP_SEARCH && value_pool.size() > 0 && mode < 6) begin
            r.value = value_pool[$urandom_range(0, value_pool.size() - 1)];
        end else if (mode < 3) begin
            r.value = $urandom;
        end else if (mode < 5) begin
            r.value = 32'($urandom_range(0, 6)) - 32'sd3;
        end else if (mode < 7) begin
            case ($urandom_range(0, 3))
                0:       r.value = 32'h7fff_ffff;
                1:       r.value = 32'h8000_0000;
                2:       r.value = '0;
                default: r.value = '1;
            endcase
        end else begin
            r.value = $urandom;
        end
    endtask

    // present one beat, wait for the accept, then maybe idle
    task automatic send_list_request(input t_req r, input int idle_pct);
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        track_list_len(r);
        items_sent++;
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    initial begin
        t_req directed [$];
        t_req req;
        int   sent;
        int   phase;
        int   phase_len;
        int   insert_pct;
        int   idle_pct;
        int   k;

        i_rst_n = 1'b0;
        start   = 1'b0;
        i_req   = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty list, bad inserts, append, duplicates, first match, edges
        directed.push_back(mk_req(OP_REMOVE, 0, 0));
        directed.push_back(mk_req(OP_READ,   0, 0));
        directed.push_back(mk_req(OP_SEARCH, 0, 0));
        directed.push_back(mk_req(OP_INSERT, 1, 5));
        directed.push_back(mk_req(OP_INSERT, 0, 32'h7fff_ffff));
        directed.push_back(mk_req(OP_INSERT, 1, 32'h8000_0000));
        directed.push_back(mk_req(OP_INSERT, 0, -2));
        directed.push_back(mk_req(OP_INSERT, 1, -2));
        directed.push_back(mk_req(OP_INSERT, 64, 7));
        directed.push_back(mk_req(OP_INSERT, 5, 7));
        directed.push_back(mk_req(OP_READ,   0, 0));
        directed.push_back(mk_req(OP_READ,   3, 0));
        directed.push_back(mk_req(OP_READ,   4, 0));
        directed.push_back(mk_req(OP_READ,   64, 0));
        directed.push_back(mk_req(OP_SEARCH, 0, -2));
        directed.push_back(mk_req(OP_SEARCH, 0, 32'h8000_0000));
        directed.push_back(mk_req(OP_SEARCH, 0, 0));
        directed.push_back(mk_req(OP_REMOVE, 4, 0));
        directed.push_back(mk_req(OP_REMOVE, 64, 0));
        directed.push_back(mk_req(OP_REMOVE, 1, 0));
        directed.push_back(mk_req(OP_REMOVE, 2, 0));
        directed.push_back(mk_req(OP_READ,   1, 0));
        directed.push_back(mk_req(OP_REMOVE, 0, 0));
        directed.push_back(mk_req(OP_REMOVE, 0, 0));
        directed.push_back(mk_req(OP_READ,   0, 0));
        foreach (directed[i])
            send_list_request(directed[i], 20);

        // random phases: fill, mix, drain, mix
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            phase_len = $urandom_range(60, 160);
            case (phase % 4)
                0:       insert_pct = 80;
                2:       insert_pct = 12;
                default: insert_pct = 40;
            endcase
            idle_pct = 15 * $urandom_range(0, 2);
            for (k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
                if (sent >= RANDOM_ITEMS - QUIET_TAIL)
                    idle_pct = 0;
                make_list_request(insert_pct, req);
                send_list_request(req, idle_pct);
                sent++;
            end
            phase++;
        end
        start <= 1'b0;

        // drain outstanding responses, then allow for the pipeline
        do
            @(posedge i_clk);
        while (chk_pending != 0);
        repeat (4) @(posedge i_clk);

        $display("summary: %0d requests (%0d directed) over %0d random phases",
                 items_sent, directed.size(), phase);
        $display("summary: list filled to capacity %0d times, drained to empty %0d times",
                 full_hits, empty_hits);
        if (chk_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/pal_pkg.sv
rtl/core/pal_cell.sv
rtl/core/positional_array_list.sv
tb/sv/positional_array_list_checker.sv
tb/sv/tb_top.sv
